// ===== rtl/core/psg_pkg.sv =====
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types, constants and the amplitude table of the tone/noise generator.
// ----------------------------------------------------------------------------
package psg_pkg;

	localparam int PERIOD_BITS = 10;
	localparam int CNT_W       = 16;
	localparam int RES_W       = 25;
	localparam int STEP_W      = 24;
	localparam int RATE_W      = 18;
	localparam int AMP_W       = 13;
	localparam int SMP_W       = 14;
	localparam int ACC_W       = 17;
	localparam int DVD_W       = 25;
	localparam int DSR_W       = 18;
	localparam int DIV_STEPS   = 25;
	localparam int CH_W        = 2;
	localparam int MIX_W       = 3;
	localparam int CFG_W       = 32;
	localparam int CFG_IDX_W   = 3;

	localparam logic [15:0] LFSR_SEED = 16'h8000;
	localparam logic [15:0] LFSR_TAPS = 16'h0009;
	localparam logic [7:0]  PAN_DIV   = 8'd254;
	localparam logic [7:0]  PAN_MID   = 8'd127;

	// x / 254 == ((x >> 1) * PAN_RECIP) >> PAN_SHIFT, exact for x below 2^21
	localparam logic [20:0] PAN_RECIP = 21'd1056833;
	localparam int          PAN_SHIFT = 27;

	// register file indexes
	localparam logic [2:0] REG_TONE0 = 3'd0;
	localparam logic [2:0] REG_VOL0  = 3'd1;
	localparam logic [2:0] REG_TONE1 = 3'd2;
	localparam logic [2:0] REG_VOL1  = 3'd3;
	localparam logic [2:0] REG_TONE2 = 3'd4;
	localparam logic [2:0] REG_VOL2  = 3'd5;
	localparam logic [2:0] REG_NOISE = 3'd6;
	localparam logic [2:0] REG_VOL3  = 3'd7;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CLOCK_STEP,
		CFG_SAMPLE_RATE,
		CFG_STEREO_MODE,
		CFG_OUTPUT_DIVISOR,
		CFG_PAN_ALL
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLK,
		S_TRD,
		S_TEVAL,
		S_TDIV,
		S_NOISE,
		S_PAN,
		S_PDIV,
		S_FL,
		S_FR,
		S_FDIV,
		S_OUT
	} state_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DVD_W-1:0] quot;
		logic [DSR_W-1:0] rem;
	} div_rsp_t;

	// attenuation code to linear amplitude
	function automatic logic [AMP_W-1:0] amp_lut(input logic [3:0] code);
		logic [AMP_W-1:0] a;
		case (code)
			4'd0:    a = 13'd8000;
			4'd1:    a = 13'd6355;
			4'd2:    a = 13'd5048;
			4'd3:    a = 13'd4009;
			4'd4:    a = 13'd3185;
			4'd5:    a = 13'd2530;
			4'd6:    a = 13'd2010;
			4'd7:    a = 13'd1596;
			4'd8:    a = 13'd1268;
			4'd9:    a = 13'd1007;
			4'd10:   a = 13'd800;
			4'd11:   a = 13'd635;
			4'd12:   a = 13'd505;
			4'd13:   a = 13'd401;
			4'd14:   a = 13'd318;
			default: a = 13'd0;
		endcase
		return a;
	endfunction

endpackage

// ===== rtl/core/psg_if.sv =====
// ----------------------------------------------------------------------------
// psg_if
// Valid/ready channels: command items in, sample items out.
// ----------------------------------------------------------------------------
interface psg_cmd_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] write_byte;

	modport source (output valid, output opcode, output write_byte, input ready);
	modport sink   (input valid, input opcode, input write_byte, output ready);
endinterface

interface psg_smp_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] left_sample;
	logic signed [15:0] right_sample;

	modport source (output valid, output left_sample, output right_sample, input ready);
	modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

// ===== rtl/core/psg_div.sv =====
// ----------------------------------------------------------------------------
// psg_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psg_div (
	input  logic               clk,
	input  logic               arst_n,
	input  psg_pkg::div_req_t  req,
	output psg_pkg::div_rsp_t  rsp
);

	logic [psg_pkg::DSR_W-1:0] rem_q;
	logic [psg_pkg::DVD_W-1:0] dq_q;
	logic [psg_pkg::DSR_W-1:0] dsr_q;
	logic [4:0]                cnt_q;
	logic                      busy_q;
	logic                      done_q;

	logic [psg_pkg::DSR_W:0]   trial;
	logic                      ge;
	logic [psg_pkg::DSR_W:0]   diff;

	// one trial subtraction
	always_comb begin
		trial = {rem_q, dq_q[psg_pkg::DVD_W-1]};
		ge    = trial >= {1'b0, dsr_q};
		diff  = trial - {1'b0, dsr_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(psg_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dq_q  <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[psg_pkg::DSR_W-1:0] : trial[psg_pkg::DSR_W-1:0];
			dq_q  <= {dq_q[psg_pkg::DVD_W-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = dq_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== rtl/core/psg_tone_noise_generator_top.sv =====
// ----------------------------------------------------------------------------
// psg_tone_noise_generator_top
// Three square-wave tones and one LFSR noise channel, mono or panned stereo.
// ----------------------------------------------------------------------------
// Command item: taken while the block is idle, no result.
// Render item: one shared divider pass for the clock step, one per
// tone channel that wraps, one or two for the output divisor; in stereo each
// of the eight pan weights passes through S_PAN and then S_PDIV.
// One item at a time; a finished sample waits in the output register.
// Reset is asynchronous; tone state memories read as reset values until written.
module psg_tone_noise_generator_top (
	input  logic                           clk,
	input  logic                           arst_n,
	psg_cmd_if.sink                        cmd,
	psg_smp_if.source                      smp,
	input  logic                           cfg_we,
	input  logic [psg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [psg_pkg::CFG_W-1:0]      cfg_wdata
);

	psg_pkg::state_t state_q, state_d;

	// configuration
	logic [psg_pkg::STEP_W-1:0] clock_step_q;
	logic [psg_pkg::RATE_W-1:0] sample_rate_q;
	logic                       stereo_q;
	logic [7:0]                 divisor_q;
	logic [31:0]                pan_q;

	// command state
	logic [9:0] reg_file_q [8];
	logic [2:0] latch_q;
	logic [3:0] amp_idx_q [4];
	logic [2:0] noise_mode_q;
	logic [15:0] lfsr_q;
	logic [15:0] noise_cnt_q;

	// tone memories: period, and {polarity, count}
	logic [psg_pkg::PERIOD_BITS-1:0] period_mem [3];
	logic [psg_pkg::CNT_W:0]         cnt_mem [3];
	logic [2:0]                      per_vld_q;
	logic [2:0]                      cnt_vld_q;
	logic [psg_pkg::PERIOD_BITS-1:0] per_rd_s1;
	logic                            per_vld_s1;
	logic [psg_pkg::CNT_W:0]         cnt_rd_s1;
	logic                            cnt_vld_s1;

	// render datapath
	logic [psg_pkg::RES_W-1:0]        residue_q;
	logic [psg_pkg::CNT_W-1:0]        n_q;
	logic [psg_pkg::CH_W-1:0]         ch_q;
	logic [psg_pkg::MIX_W-1:0]        mi_q;
	logic                             fsel_q;
	logic                             sign_q;
	logic [psg_pkg::PERIOD_BITS-1:0]  p_q;
	logic signed [psg_pkg::SMP_W-1:0] s_q [4];
	logic signed [psg_pkg::ACC_W-1:0] acc_l_q;
	logic signed [psg_pkg::ACC_W-1:0] acc_r_q;
	logic signed [15:0]               left_q;
	logic signed [15:0]               out_l_q;
	logic signed [15:0]               out_r_q;
	logic                             out_vld_q;
	logic [20:0]                      prod_s1;
	logic                             pneg_s1;

	psg_pkg::div_req_t div_req;
	psg_pkg::div_rsp_t div_rsp;

	psg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// handshakes
	logic cmd_acc, acc_wr, acc_rd, out_fire;
	assign cmd.ready = (state_q == psg_pkg::S_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign acc_wr    = cmd_acc && !cmd.opcode;
	assign acc_rd    = cmd_acc && cmd.opcode;
	assign out_fire  = (state_q == psg_pkg::S_OUT) && (!out_vld_q || smp.ready);

	assign smp.valid        = out_vld_q;
	assign smp.left_sample  = out_l_q;
	assign smp.right_sample = out_r_q;

	// command byte decode
	logic [2:0] cmd_idx;
	logic [9:0] cmd_val;
	logic       per_we;
	always_comb begin
		if (cmd.write_byte[7]) begin
			cmd_idx = cmd.write_byte[6:4];
			cmd_val = {reg_file_q[cmd_idx][9:4], cmd.write_byte[3:0]};
		end else begin
			cmd_idx = latch_q;
			cmd_val = {cmd.write_byte[5:0], reg_file_q[cmd_idx][3:0]};
		end
		per_we = 1'b0;
		case (cmd_idx) inside
			psg_pkg::REG_TONE0, psg_pkg::REG_TONE1, psg_pkg::REG_TONE2: per_we = acc_wr;
			default: per_we = 1'b0;
		endcase
	end

	// tone evaluation
	logic [psg_pkg::PERIOD_BITS-1:0] per_eff;
	logic [psg_pkg::CNT_W-1:0]       cnt_eff;
	logic                            pol_eff;
	logic                            need_div;
	logic                            tone_fin;
	logic                            pol_new;
	logic [psg_pkg::CNT_W-1:0]       cnt_new;
	logic [psg_pkg::AMP_W-1:0]       amp_ch;
	logic signed [psg_pkg::SMP_W-1:0] s_new;
	always_comb begin
		per_eff = per_vld_s1 ? per_rd_s1 : psg_pkg::PERIOD_BITS'(1);
		{pol_eff, cnt_eff} = cnt_vld_s1 ? cnt_rd_s1 : {1'b1, psg_pkg::CNT_W'(0)};
		need_div = (per_eff > psg_pkg::PERIOD_BITS'(1)) && (cnt_eff < n_q);
		tone_fin = 1'b0;
		pol_new  = pol_eff;
		cnt_new  = cnt_eff;
		if (state_q == psg_pkg::S_TEVAL && !need_div) begin
			tone_fin = 1'b1;
			if (per_eff <= psg_pkg::PERIOD_BITS'(1)) begin
				pol_new = 1'b1;
			end else begin
				cnt_new = cnt_eff - n_q;
			end
		end else if (state_q == psg_pkg::S_TDIV && div_rsp.done) begin
			tone_fin = 1'b1;
			pol_new  = pol_eff ^ ~div_rsp.quot[0];
			cnt_new  = psg_pkg::CNT_W'(per_eff) - psg_pkg::CNT_W'(1)
				- psg_pkg::CNT_W'(div_rsp.rem[psg_pkg::PERIOD_BITS-1:0]);
		end
		amp_ch = psg_pkg::amp_lut(amp_idx_q[ch_q]);
		s_new  = pol_new ? $signed({1'b0, amp_ch}) : -$signed({1'b0, amp_ch});
	end

	// noise step
	logic [psg_pkg::ACC_W-1:0]        reload;
	logic [15:0]                      nc_new;
	logic [15:0]                      lfsr_new;
	logic                             fb;
	logic [psg_pkg::AMP_W-1:0]        amp_n;
	logic signed [psg_pkg::SMP_W-1:0] s3_new;
	always_comb begin
		case (noise_mode_q[1:0])
			2'd0:    reload = psg_pkg::ACC_W'(32);
			2'd1:    reload = psg_pkg::ACC_W'(64);
			2'd2:    reload = psg_pkg::ACC_W'(128);
			default: reload = psg_pkg::ACC_W'({p_q, 1'b0});
		endcase
		fb = noise_mode_q[2] ? ^(lfsr_q & psg_pkg::LFSR_TAPS) : lfsr_q[0];
		if (noise_cnt_q < n_q) begin
			nc_new   = 16'(reload + psg_pkg::ACC_W'(noise_cnt_q) - psg_pkg::ACC_W'(n_q));
			lfsr_new = {fb, lfsr_q[15:1]};
		end else begin
			nc_new   = noise_cnt_q - n_q;
			lfsr_new = lfsr_q;
		end
		amp_n  = psg_pkg::amp_lut(amp_idx_q[3]);
		s3_new = lfsr_new[0] ? $signed({1'b0, amp_n}) : -$signed({1'b0, amp_n});
	end

	// pan weight and product
	logic [7:0]                       pan_b;
	logic signed [9:0]                pan_w;
	logic [7:0]                       w_sel;
	logic signed [psg_pkg::SMP_W-1:0] s_sel;
	logic [psg_pkg::AMP_W-1:0]        s_mag;
	logic [20:0]                      prod;
	always_comb begin
		pan_b = pan_q[{mi_q[2:1], 3'b000} +: 8];
		if (mi_q[0]) begin
			pan_w = $signed({{2{pan_b[7]}}, pan_b}) + $signed({2'b00, psg_pkg::PAN_MID});
		end else begin
			pan_w = $signed({2'b00, psg_pkg::PAN_MID}) - $signed({{2{pan_b[7]}}, pan_b});
		end
		if (pan_w < 0) begin
			w_sel = 8'd0;
		end else if (pan_w > $signed({2'b00, psg_pkg::PAN_DIV})) begin
			w_sel = psg_pkg::PAN_DIV;
		end else begin
			w_sel = pan_w[7:0];
		end
		s_sel = s_q[mi_q[2:1]];
		s_mag = s_sel[psg_pkg::SMP_W-1] ? psg_pkg::AMP_W'(-s_sel) : psg_pkg::AMP_W'(s_sel);
		prod  = 21'(s_mag) * 21'(w_sel);
	end

	// registered product divided by 254 through the reciprocal, sign restored
	logic [40:0]               pan_prod;
	logic [psg_pkg::ACC_W-1:0] pan_mag;
	logic [psg_pkg::ACC_W-1:0] pan_term;
	always_comb begin
		pan_prod = 41'(prod_s1[20:1]) * 41'(psg_pkg::PAN_RECIP);
		pan_mag  = psg_pkg::ACC_W'(pan_prod[psg_pkg::PAN_SHIFT +: 14]);
		pan_term = pneg_s1 ? -pan_mag : pan_mag;
	end

	// magnitudes and signed quotient
	logic [psg_pkg::ACC_W-1:0]      accl_mag, accr_mag;
	logic [psg_pkg::RES_W-1:0]      res_sum;
	logic signed [psg_pkg::ACC_W:0] q_s;
	assign accl_mag = acc_l_q[psg_pkg::ACC_W-1] ? psg_pkg::ACC_W'(-acc_l_q) : acc_l_q;
	assign accr_mag = acc_r_q[psg_pkg::ACC_W-1] ? psg_pkg::ACC_W'(-acc_r_q) : acc_r_q;
	assign res_sum  = residue_q + psg_pkg::RES_W'(clock_step_q);
	assign q_s = sign_q ? -$signed({1'b0, div_rsp.quot[psg_pkg::ACC_W-1:0]})
	                    : $signed({1'b0, div_rsp.quot[psg_pkg::ACC_W-1:0]});

	// divider requests
	logic div_neg;
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = psg_pkg::DSR_W'(1);
		div_neg          = 1'b0;
		unique case (state_q)
			psg_pkg::S_IDLE: begin
				div_req.start    = acc_rd;
				div_req.dividend = res_sum;
				div_req.divisor  = (sample_rate_q == '0) ? psg_pkg::DSR_W'(1) : sample_rate_q;
			end
			psg_pkg::S_TEVAL: begin
				div_req.start    = need_div;
				div_req.dividend = psg_pkg::DVD_W'(n_q - cnt_eff - psg_pkg::CNT_W'(1));
				div_req.divisor  = psg_pkg::DSR_W'(per_eff);
			end
			psg_pkg::S_FL, psg_pkg::S_FR: begin
				div_req.start    = 1'b1;
				div_req.dividend = psg_pkg::DVD_W'((state_q == psg_pkg::S_FL) ? accl_mag : accr_mag);
				div_req.divisor  = (divisor_q == 8'd0) ? psg_pkg::DSR_W'(1)
				                                       : psg_pkg::DSR_W'(divisor_q);
				div_neg          = (state_q == psg_pkg::S_FL) ? acc_l_q[psg_pkg::ACC_W-1]
				                                              : acc_r_q[psg_pkg::ACC_W-1];
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			psg_pkg::S_IDLE:  if (acc_rd) state_d = psg_pkg::S_CLK;
			psg_pkg::S_CLK:   if (div_rsp.done) state_d = psg_pkg::S_TRD;
			psg_pkg::S_TRD:   state_d = psg_pkg::S_TEVAL;
			psg_pkg::S_TEVAL,
			psg_pkg::S_TDIV: begin
				if (state_q == psg_pkg::S_TEVAL && need_div) begin
					state_d = psg_pkg::S_TDIV;
				end else if (tone_fin) begin
					state_d = (ch_q == psg_pkg::CH_W'(2)) ? psg_pkg::S_NOISE : psg_pkg::S_TRD;
				end
			end
			psg_pkg::S_NOISE: state_d = stereo_q ? psg_pkg::S_PAN : psg_pkg::S_FL;
			psg_pkg::S_PAN:   state_d = psg_pkg::S_PDIV;
			psg_pkg::S_PDIV:  state_d = (mi_q == '1) ? psg_pkg::S_FL : psg_pkg::S_PAN;
			psg_pkg::S_FL,
			psg_pkg::S_FR:    state_d = psg_pkg::S_FDIV;
			psg_pkg::S_FDIV: begin
				if (div_rsp.done) begin
					state_d = (!fsel_q && stereo_q) ? psg_pkg::S_FR : psg_pkg::S_OUT;
				end
			end
			psg_pkg::S_OUT:   if (out_fire) state_d = psg_pkg::S_IDLE;
			default:          state_d = psg_pkg::S_IDLE;
		endcase
	end

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= psg_pkg::S_IDLE;
			clock_step_q  <= psg_pkg::STEP_W'(223721);
			sample_rate_q <= psg_pkg::RATE_W'(44100);
			stereo_q      <= 1'b0;
			divisor_q     <= 8'd1;
			pan_q         <= '0;
			for (int i = 0; i < 8; i++) reg_file_q[i] <= '0;
			for (int i = 0; i < 4; i++) amp_idx_q[i] <= 4'hF;
			latch_q       <= '0;
			noise_mode_q  <= '0;
			lfsr_q        <= psg_pkg::LFSR_SEED;
			noise_cnt_q   <= '0;
			residue_q     <= '0;
			per_vld_q     <= '0;
			cnt_vld_q     <= '0;
			out_vld_q     <= 1'b0;
			ch_q          <= '0;
			mi_q          <= '0;
			fsel_q        <= 1'b0;
		end else begin
			state_q <= state_d;

			// configuration writes
			if (cfg_we) begin
				case (cfg_index)
					psg_pkg::CFG_CLOCK_STEP:     clock_step_q  <= cfg_wdata[psg_pkg::STEP_W-1:0];
					psg_pkg::CFG_SAMPLE_RATE:    sample_rate_q <= cfg_wdata[psg_pkg::RATE_W-1:0];
					psg_pkg::CFG_STEREO_MODE:    stereo_q      <= cfg_wdata[0];
					psg_pkg::CFG_OUTPUT_DIVISOR: divisor_q     <= cfg_wdata[7:0];
					psg_pkg::CFG_PAN_ALL:        pan_q         <= cfg_wdata;
					default: ;
				endcase
			end

			// command byte
			if (acc_wr) begin
				if (cmd.write_byte[7]) latch_q <= cmd_idx;
				reg_file_q[cmd_idx] <= cmd_val;
				case (cmd_idx) inside
					psg_pkg::REG_VOL0, psg_pkg::REG_VOL1, psg_pkg::REG_VOL2, psg_pkg::REG_VOL3:
						amp_idx_q[cmd_idx[2:1]] <= cmd.write_byte[3:0];
					psg_pkg::REG_NOISE: begin
						noise_mode_q <= cmd.write_byte[2:0];
						lfsr_q       <= psg_pkg::LFSR_SEED;
					end
					default: ;
				endcase
			end
			if (per_we) per_vld_q[cmd_idx[2:1]] <= 1'b1;

			// clock residue
			if (acc_rd) residue_q <= res_sum;
			if (state_q == psg_pkg::S_CLK && div_rsp.done) begin
				residue_q <= psg_pkg::RES_W'(div_rsp.rem);
				ch_q      <= '0;
			end

			// tone channel sequencing
			if (tone_fin) begin
				cnt_vld_q[ch_q] <= 1'b1;
				ch_q <= ch_q + psg_pkg::CH_W'(1);
			end

			// noise
			if (state_q == psg_pkg::S_NOISE) begin
				noise_cnt_q <= nc_new;
				lfsr_q      <= lfsr_new;
				mi_q        <= '0;
			end

			if (state_q == psg_pkg::S_PDIV) mi_q <= mi_q + psg_pkg::MIX_W'(1);
			if (state_q == psg_pkg::S_FL) fsel_q <= 1'b0;
			if (state_q == psg_pkg::S_FR) fsel_q <= 1'b1;

			// output register
			if (out_fire) begin
				out_vld_q <= 1'b1;
			end else if (smp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// tone memories: write, and registered read
	always_ff @(posedge clk) begin
		if (per_we) period_mem[cmd_idx[2:1]] <= cmd_val;
		if (tone_fin) cnt_mem[ch_q] <= {pol_new, cnt_new};
		if (state_q == psg_pkg::S_TRD) begin
			per_rd_s1  <= period_mem[ch_q];
			per_vld_s1 <= per_vld_q[ch_q];
			cnt_rd_s1  <= cnt_mem[ch_q];
			cnt_vld_s1 <= cnt_vld_q[ch_q];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == psg_pkg::S_CLK && div_rsp.done) begin
			n_q <= (div_rsp.quot[psg_pkg::DVD_W-1:psg_pkg::CNT_W] != '0)
				? '1 : div_rsp.quot[psg_pkg::CNT_W-1:0];
		end
		if (div_req.start) sign_q <= div_neg;
		if (state_q == psg_pkg::S_TEVAL) p_q <= per_eff;
		if (tone_fin) s_q[ch_q] <= s_new;
		if (state_q == psg_pkg::S_NOISE) begin
			s_q[3]  <= s3_new;
			acc_r_q <= '0;
			acc_l_q <= stereo_q ? '0 : psg_pkg::ACC_W'(s_q[0]) + psg_pkg::ACC_W'(s_q[1])
				+ psg_pkg::ACC_W'(s_q[2]) + psg_pkg::ACC_W'(s3_new);
		end
		if (state_q == psg_pkg::S_PAN) begin
			prod_s1 <= prod;
			pneg_s1 <= s_sel[psg_pkg::SMP_W-1];
		end
		if (state_q == psg_pkg::S_PDIV) begin
			if (mi_q[0]) acc_r_q <= acc_r_q + $signed(pan_term);
			else         acc_l_q <= acc_l_q + $signed(pan_term);
		end
		if (state_q == psg_pkg::S_FDIV && div_rsp.done && !fsel_q) left_q <= q_s[15:0];
		if (out_fire) begin
			if (stereo_q) begin
				out_l_q <= left_q;
				out_r_q <= q_s[15:0];
			end else begin
				out_l_q <= left_q;
				out_r_q <= '0;
			end
		end
	end

	// the divider is never restarted while a pass is running
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// a sample appears only out of the output state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == psg_pkg::S_OUT))
		else $error("sample valid without render completion");

	// tone sequencing stays on the three channels
	a_ch_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == psg_pkg::S_TRD || state_q == psg_pkg::S_TEVAL
		 || state_q == psg_pkg::S_TDIV) |-> ch_q != 2'd3)
		else $error("tone channel index out of range");

	// commands are taken only between renders; a render command starts the clock divide
	a_cmd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc_rd |=> state_q == psg_pkg::S_CLK && div_rsp.busy)
		else $error("render did not start the clock divide");

endmodule
